// File: sv/setpoint_ramp_generator_top_assert.svh
// Assertion macros for the setpoint ramp generator.
// Used by setpoint_ramp_generator_top; expects clk and arst_n in scope.
`ifndef SETPOINT_RAMP_GENERATOR_TOP_ASSERT_SVH
`define SETPOINT_RAMP_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define SRG_ASSERT_SAME(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
	else $error(msg);
`define SRG_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
	else $error(msg);
`else
`define SRG_ASSERT_SAME(lbl, ant, cons, msg)
`define SRG_ASSERT_NEXT(lbl, ant, cons, msg)
`endif
`endif

// File: sv/srg_pkg.sv
// Shared constants for the setpoint ramp generator.
// No dependencies.
package srg_pkg;
	localparam int DATA_W          = 32;
	localparam int STEP_W          = 32;
	localparam int MAX_SPEED_W     = 31;
	localparam int RATE_W          = 16;
	localparam int CFG_DATA_W      = 31;
	localparam int CFG_IDX_W       = 1;
	localparam int COORD_WIDTH_DEF = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_RATE = 1'd1;

	localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RST = 31'd98304;
	localparam logic [RATE_W-1:0]      LOOP_RATE_RST = 16'd50;
endpackage

// File: sv/srg_in_if.sv
// Input channel: goal or tick word with valid/ready.
// Depends on srg_pkg.
interface srg_in_if;
	import srg_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic signed [DATA_W-1:0] goal_x;
	logic signed [DATA_W-1:0] goal_y;
	logic signed [DATA_W-1:0] goal_z;
	logic signed [DATA_W-1:0] goal_yaw;
	logic                     jump;
	modport source (output valid, action, goal_x, goal_y, goal_z, goal_yaw, jump,
		input ready);
	modport sink (input valid, action, goal_x, goal_y, goal_z, goal_yaw, jump,
		output ready);
endinterface

// File: sv/srg_out_if.sv
// Output channel: reference word with valid/ready.
// Depends on srg_pkg.
interface srg_out_if;
	import srg_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] ref_x;
	logic signed [DATA_W-1:0] ref_y;
	logic signed [DATA_W-1:0] ref_z;
	logic signed [DATA_W-1:0] ref_yaw;
	modport source (output valid, ref_x, ref_y, ref_z, ref_yaw, input ready);
	modport sink (input valid, ref_x, ref_y, ref_z, ref_yaw, output ready);
endinterface

// File: sv/setpoint_ramp_generator_top.sv
// Setpoint ramp generator: goal words arm a ramp, tick words emit the reference.
// Goal words are taken in S_IDLE. Plain and jump ticks pass through S_FIN to the output register.
// A tick that recomputes steps runs one shared adder: square of x, y and z, root, scale,
// then multiply/divide for each of the four axes, and finish.
// Not ready while a tick is in work; the output register holds a result until taken.
// Async active-low reset clears goal, reference, steps, flags and output; config registers take defaults.
`include "setpoint_ramp_generator_top_assert.svh"
module setpoint_ramp_generator_top #(
	parameter int COORD_WIDTH = srg_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [srg_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [srg_pkg::CFG_DATA_W-1:0]  wr_data,
	srg_in_if.sink                          goal_in,
	srg_out_if.source                       ref_out
);
	import srg_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int MW    = CW + 1;
	localparam int SW    = 2 * CW + 4;
	localparam int RW    = CW + 2;
	localparam int NW    = MW + MAX_SPEED_W;
	localparam int DW    = RW + RATE_W;
	localparam int UW    = ((SW > NW) ? SW : NW) + 1;
	localparam int CPW   = (MW > STEP_W + 1) ? MW : STEP_W + 1;
	localparam int CNT_W = $clog2(UW + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SQ    = 7'b0000010,
		S_ROOT  = 7'b0000100,
		S_SCALE = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_FIN   = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic signed [CW-1:0]      goal_q [4];
	logic signed [CW-1:0]      ref_q [4];
	logic signed [STEP_W-1:0]  step_q [4];
	logic                      pending_q, jump_q, skip_q, oval_q;
	logic [MAX_SPEED_W-1:0]    ms_q;
	logic [RATE_W-1:0]         lr_q;
	logic [DATA_W-1:0]         out_q [4];
	logic [CNT_W-1:0]          cnt_q;
	logic [1:0]                axis_q;

	logic [UW-1:0]             acc_q, mc_q, sh_q, rem_q;
	logic [RW-1:0]             root_q;
	logic [NW-1:0]             quot_q;
	logic [DW-1:0]             dvs_q;

	logic [MW-1:0]             d_mag [4];
	logic                      d_neg [4];
	logic signed [CW-1:0]      upd_ref [4];
	logic [DATA_W-1:0]         ref_word [4];
	logic [DATA_W-1:0]         upd_word [4];
	logic signed [CW-1:0]      gin_wrap [4];
	logic signed [DATA_W-1:0]  gin [4];

	logic [UW-1:0]             alu_a, alu_b;
	logic                      alu_sub;
	logic [UW:0]               alu_res;
	logic [UW-1:0]             acc_nx;
	logic [NW-1:0]             quot_nx;
	logic [MAX_SPEED_W-1:0]    smag;
	logic signed [STEP_W-1:0]  step_new;
	logic [RATE_W-1:0]         rate;
	logic                      in_acc, slot_free;
	logic [1:0]                axis_nx;

	assign gin[0] = goal_in.goal_x;
	assign gin[1] = goal_in.goal_y;
	assign gin[2] = goal_in.goal_z;
	assign gin[3] = goal_in.goal_yaw;

	for (genvar i = 0; i < 4; i++) begin : g_axis
		logic signed [MW-1:0]        diff;
		logic [STEP_W-1:0]           step_mag;
		logic signed [CW+STEP_W-1:0] step_ext;
		logic signed [CW+DATA_W-1:0] ref_ext, upd_ext, gin_ext;
		always_comb begin
			diff     = MW'(goal_q[i]) - MW'(ref_q[i]);
			d_neg[i] = diff[MW-1];
			d_mag[i] = d_neg[i] ? MW'(-diff) : MW'(diff);
			step_mag = step_q[i][STEP_W-1] ? STEP_W'(-step_q[i]) : STEP_W'(step_q[i]);
			step_ext = step_q[i];
			if (CPW'(d_mag[i]) > CPW'({step_mag, 1'b0})) begin
				upd_ref[i] = ref_q[i] + step_ext[CW-1:0];
			end else begin
				upd_ref[i] = goal_q[i];
			end
			ref_ext     = ref_q[i];
			upd_ext     = upd_ref[i];
			ref_word[i] = ref_ext[DATA_W-1:0];
			upd_word[i] = upd_ext[DATA_W-1:0];
			gin_ext     = gin[i];
			gin_wrap[i] = gin_ext[CW-1:0];
		end
	end

	assign rate      = (lr_q == '0) ? RATE_W'(1) : lr_q;
	assign in_acc    = goal_in.valid && goal_in.ready;
	assign slot_free = !oval_q || ref_out.ready;
	assign axis_nx   = axis_q + 2'd1;

	// shared adder/subtractor
	always_comb begin
		case (state_q)
			S_SQ, S_MUL: begin
				alu_a   = acc_q;
				alu_b   = mc_q;
				alu_sub = 1'b0;
			end
			S_ROOT: begin
				alu_a   = {rem_q[UW-3:0], sh_q[SW-1:SW-2]};
				alu_b   = UW'({root_q, 2'b01});
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_a   = {rem_q[UW-2:0], sh_q[NW-1]};
				alu_b   = UW'(dvs_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
		alu_res  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (UW+1)'(alu_sub);
		acc_nx   = sh_q[0] ? alu_res[UW-1:0] : acc_q;
		quot_nx  = {quot_q[NW-2:0], alu_res[UW]};
		smag     = (|quot_nx[NW-1:MAX_SPEED_W]) ? '1 : quot_nx[MAX_SPEED_W-1:0];
		step_new = d_neg[axis_q] ? -STEP_W'(smag) : STEP_W'(smag);
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pending_q <= 1'b0;
			jump_q    <= 1'b0;
			skip_q    <= 1'b0;
			oval_q    <= 1'b0;
			ms_q      <= MAX_SPEED_RST;
			lr_q      <= LOOP_RATE_RST;
			cnt_q     <= '0;
			axis_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				goal_q[i] <= '0;
				ref_q[i]  <= '0;
				step_q[i] <= '0;
				out_q[i]  <= '0;
			end
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_MAX_SPEED: ms_q <= wr_data[MAX_SPEED_W-1:0];
					REG_LOOP_RATE: lr_q <= wr_data[RATE_W-1:0];
					default: ;
				endcase
			end
			if (oval_q && ref_out.ready && !(state_q == S_FIN && slot_free)) begin
				oval_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q  <= '0;
						axis_q <= '0;
						if (goal_in.action) begin
							for (int i = 0; i < 4; i++) goal_q[i] <= gin_wrap[i];
							jump_q    <= goal_in.jump;
							pending_q <= 1'b1;
						end else if (pending_q && jump_q) begin
							for (int i = 0; i < 4; i++) ref_q[i] <= goal_q[i];
							pending_q <= 1'b0;
							skip_q    <= 1'b1;
							state_q   <= S_FIN;
						end else if (pending_q) begin
							pending_q <= 1'b0;
							state_q   <= S_SQ;
						end else begin
							skip_q  <= 1'b0;
							state_q <= S_FIN;
						end
					end
				end
				S_SQ: begin
					if (cnt_q == CNT_W'(MW - 1)) begin
						cnt_q <= '0;
						if (axis_q == 2'd2) begin
							state_q <= S_ROOT;
						end else begin
							axis_q <= axis_nx;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROOT: begin
					if (cnt_q == CNT_W'(RW - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SCALE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SCALE: begin
					axis_q <= '0;
					cnt_q  <= '0;
					if (root_q == '0) begin
						for (int i = 0; i < 4; i++) begin
							ref_q[i]  <= goal_q[i];
							step_q[i] <= '0;
						end
						skip_q  <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(MAX_SPEED_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(NW - 1)) begin
						cnt_q          <= '0;
						step_q[axis_q] <= step_new;
						if (axis_q == 2'd3) begin
							skip_q  <= 1'b0;
							state_q <= S_FIN;
						end else begin
							axis_q  <= axis_nx;
							state_q <= S_MUL;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					if (slot_free) begin
						for (int i = 0; i < 4; i++) begin
							if (!skip_q) ref_q[i] <= upd_ref[i];
							out_q[i] <= skip_q ? ref_word[i] : upd_word[i];
						end
						oval_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// iterative datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_q <= '0;
				mc_q  <= UW'(d_mag[0]);
				sh_q  <= UW'(d_mag[0]);
			end
			S_SQ: begin
				if (cnt_q == CNT_W'(MW - 1)) begin
					if (axis_q == 2'd2) begin
						acc_q  <= acc_nx;
						sh_q   <= acc_nx;
						rem_q  <= '0;
						root_q <= '0;
					end else begin
						acc_q <= acc_nx;
						mc_q  <= UW'(d_mag[axis_nx]);
						sh_q  <= UW'(d_mag[axis_nx]);
					end
				end else begin
					acc_q <= acc_nx;
					mc_q  <= mc_q << 1;
					sh_q  <= sh_q >> 1;
				end
			end
			S_ROOT: begin
				sh_q <= sh_q << 2;
				if (alu_res[UW]) begin
					rem_q  <= alu_res[UW-1:0];
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= alu_a;
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			S_SCALE: begin
				dvs_q <= DW'(root_q) * DW'(rate);
				acc_q <= '0;
				mc_q  <= UW'(d_mag[0]);
				sh_q  <= UW'(ms_q);
			end
			S_MUL: begin
				if (cnt_q == CNT_W'(MAX_SPEED_W - 1)) begin
					sh_q   <= acc_nx;
					rem_q  <= '0;
					quot_q <= '0;
				end else begin
					acc_q <= acc_nx;
					mc_q  <= mc_q << 1;
					sh_q  <= sh_q >> 1;
				end
			end
			S_DIV: begin
				quot_q <= quot_nx;
				rem_q  <= alu_res[UW] ? alu_res[UW-1:0] : alu_a;
				if (cnt_q == CNT_W'(NW - 1)) begin
					acc_q <= '0;
					mc_q  <= UW'(d_mag[axis_nx]);
					sh_q  <= UW'(ms_q);
				end else begin
					sh_q <= sh_q << 1;
				end
			end
			default: ;
		endcase
	end

	assign goal_in.ready   = (state_q == S_IDLE);
	assign ref_out.valid   = oval_q;
	assign ref_out.ref_x   = out_q[0];
	assign ref_out.ref_y   = out_q[1];
	assign ref_out.ref_z   = out_q[2];
	assign ref_out.ref_yaw = out_q[3];

	`SRG_ASSERT_NEXT(a_goal_arms, in_acc && goal_in.action, pending_q && state_q == S_IDLE, "goal word did not arm the ramp")
	`SRG_ASSERT_NEXT(a_fin_emits, state_q == S_FIN && slot_free, oval_q && state_q == S_IDLE, "finished tick not presented")
	`SRG_ASSERT_SAME(a_div_nonzero, state_q == S_DIV, dvs_q != '0, "divide by zero in step scaling")
	`SRG_ASSERT_NEXT(a_jump_copies, in_acc && !goal_in.action && pending_q && jump_q, ref_q[0] == goal_q[0] && ref_q[3] == goal_q[3] && !pending_q, "jump tick did not copy goal")
endmodule
